// ===== sv/stpb_pkg.sv =====
// Package for the stepper burst positioner.
// Holds the command codes, field widths, timing constants and the types
// shared by the channel interfaces, the divider and the top level.
package stpb_pkg;

  // Burst length is a power of two: the split is a shift and a mask.
  localparam int CHUNK_LOG2 = 8;
  localparam int CHUNK      = 1 << CHUNK_LOG2;

  // Field widths.
  localparam int CMD_W    = 2;
  localparam int POS_W    = 32;
  localparam int FREQ_W   = 18;
  localparam int BURST_W  = CHUNK_LOG2 + 1;
  localparam int RELOAD_W = 16;
  localparam int FULL_W   = POS_W - CHUNK_LOG2;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_REL       = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ABS       = 2'd1;
  localparam logic [CMD_W-1:0] CMD_BURST_END = 2'd2;

  // Step timer tick rate and the accepted frequency window.
  localparam int TICK_HZ  = 1000000;
  localparam int FREQ_MIN = 20;
  localparam int FREQ_MAX = 200000;

  // Divider sizing: the dividend is the tick rate.
  localparam int DIVIDEND_W = 20;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);
  localparam logic [DIVIDEND_W-1:0] TICK_DIVIDEND = DIVIDEND_W'(TICK_HZ);

  // Sequencer states.
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EXEC   = 6'b000010,
    S_NEG    = 6'b000100,
    S_SPLIT  = 6'b001000,
    S_DIV    = 6'b010000,
    S_RESULT = 6'b100000
  } state_t;

  // Request to the period divider.
  typedef struct packed {
    logic              start;
    logic [FREQ_W-1:0] divisor;
  } div_req_t;

  // Response from the period divider.
  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== sv/stpb_chan_if.sv =====
// Channel interfaces for the stepper burst positioner.
// Valid/ready command and result channels; payload types from stpb_pkg.
interface stpb_cmd_if;
  import stpb_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic signed [POS_W-1:0] move_amount;
  logic [FREQ_W-1:0]       frequency;
  logic                    direction;

  modport source (output valid, command, move_amount, frequency, direction, input ready);
  modport sink   (input valid, command, move_amount, frequency, direction, output ready);
endinterface

interface stpb_res_if;
  import stpb_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    accepted;
  logic [BURST_W-1:0]      burst_pulses;
  logic                    step_direction;
  logic [RELOAD_W-1:0]     reload_period;
  logic signed [POS_W-1:0] position;
  logic                    motion_done;
  logic                    busy_res;

  modport source (output valid, accepted, burst_pulses, step_direction, reload_period,
                  position, motion_done, busy_res, input ready);
  modport sink   (input valid, accepted, burst_pulses, step_direction, reload_period,
                  position, motion_done, busy_res, output ready);
endinterface

// ===== sv/stpb_div.sv =====
// Restoring divider for the step timer period: tick rate over frequency.
// One quotient bit per cycle; uses the request and response types of stpb_pkg.
module stpb_div (
  input  logic              clk,
  input  logic              rst,
  input  stpb_pkg::div_req_t req,
  output stpb_pkg::div_rsp_t rsp
);
  import stpb_pkg::*;

  logic                  busy;
  logic                  done;
  logic [DIV_CNT_W-1:0]  count;
  logic [FREQ_W-1:0]     divisor;
  logic [FREQ_W-1:0]     rem;
  logic [DIVIDEND_W-1:0] quo;
  logic [FREQ_W:0]       shifted;
  logic [FREQ_W:0]       trial;
  logic                  fits;

  // Shift in the next dividend bit and try the subtraction.
  always_comb begin
    shifted = {rem, quo[DIVIDEND_W-1]};
    trial   = shifted - {1'b0, divisor};
    fits    = (shifted >= {1'b0, divisor});
  end

  // Control: count the steps and pulse done after the last one.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= DIV_CNT_W'(DIVIDEND_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (req.start) begin
      divisor <= req.divisor;
      rem     <= '0;
      quo     <= TICK_DIVIDEND;
    end else if (busy) begin
      if (fits) begin
        rem <= trial[FREQ_W-1:0];
        quo <= {quo[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem <= shifted[FREQ_W-1:0];
        quo <= {quo[DIVIDEND_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ===== sv/stepper_burst_positioner_top.sv =====
// Stepper burst positioner: command sequencer, position state and output register.
// Depends on stpb_pkg, the channels in stpb_chan_if and the divider stpb_div.
//
// Usage:
//   cmd_ch carries relative moves, absolute moves and burst-finished events.
//   res_ch returns exactly one result per command, in order.
//   A transfer happens on a rising edge with valid and ready both high.
//   The block takes one command at a time. A burst-finished event, a refused
//   move or an absolute move to the current position goes from evaluation
//   straight to the result state. An accepted move runs the step period through
//   S_SPLIT (after S_NEG when an absolute move runs in the negative direction)
//   and then waits in S_DIV on the 20-step restoring divider, one quotient bit
//   per cycle, before it offers its result; that divider sets the rate.
//   The result sits in an output register, so the next command is taken
//   while an earlier result still waits. If the receiver stalls, the next
//   result waits in the sequencer and cmd_ch stays not ready until the
//   output register frees up.
//   Reset (rst, synchronous) zeroes the position and target, ends any move
//   and empties the output register.
module stepper_burst_positioner_top (
  input  logic       clk,
  input  logic       rst,
  stpb_cmd_if.sink   cmd_ch,
  stpb_res_if.source res_ch
);
  import stpb_pkg::*;

  state_t state;

  // Motion state.
  logic [POS_W-1:0]      position;
  logic [POS_W-1:0]      target_position;
  logic [FULL_W-1:0]     full_left;
  logic [CHUNK_LOG2-1:0] remainder_pulses;
  logic                  bursts_finished;
  logic                  moving;
  logic                  move_direction;

  // Captured command.
  logic [CMD_W-1:0]  cmd_r;
  logic [POS_W-1:0]  amount_r;
  logic [FREQ_W-1:0] freq_r;
  logic              dir_r;
  logic [POS_W-1:0]  move_dist;

  // Result fields under construction.
  logic                res_accepted;
  logic [BURST_W-1:0]  res_burst;
  logic [RELOAD_W-1:0] res_reload;
  logic                res_done;

  // Output register.
  logic                out_valid;
  logic                out_accepted;
  logic [BURST_W-1:0]  out_burst;
  logic                out_dir;
  logic [RELOAD_W-1:0] out_reload;
  logic [POS_W-1:0]    out_position;
  logic                out_done;
  logic                out_busy;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic              cmd_xfer;
  logic              res_xfer;
  logic              out_free;
  logic              freq_ok;
  logic              amount_pos;
  logic [POS_W:0]    abs_diff;
  logic [BURST_W-1:0] burst;

  assign cmd_ch.ready = (state == S_IDLE);
  assign cmd_xfer     = cmd_ch.valid && cmd_ch.ready;
  assign res_xfer     = out_valid && res_ch.ready;
  assign out_free     = !out_valid || res_ch.ready;

  // Move checks and the absolute distance as a signed 33-bit difference.
  always_comb begin
    freq_ok    = (freq_r >= FREQ_W'(FREQ_MIN)) && (freq_r <= FREQ_W'(FREQ_MAX));
    amount_pos = (amount_r != '0) && !amount_r[POS_W-1];
    abs_diff   = {amount_r[POS_W-1], amount_r} - {position[POS_W-1], position};
  end

  // Length of the burst a burst-finished event launches.
  always_comb begin
    burst = '0;
    if (!bursts_finished) begin
      if (full_left != '0) begin
        burst = BURST_W'(CHUNK);
      end else begin
        burst = {1'b0, remainder_pulses};
      end
    end
  end

  // Divider launch when a move is split.
  always_comb begin
    div_req.start   = (state == S_SPLIT);
    div_req.divisor = freq_r;
  end

  stpb_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Sequencer and motion state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      position         <= '0;
      target_position  <= '0;
      full_left        <= '0;
      remainder_pulses <= '0;
      bursts_finished  <= 1'b1;
      moving           <= 1'b0;
      move_direction   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_xfer) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_RESULT;
          unique case (cmd_r)
            CMD_REL: begin
              if (amount_pos && !moving && freq_ok) begin
                move_direction  <= dir_r;
                target_position <= dir_r ? (position - amount_r) : (position + amount_r);
                state           <= S_SPLIT;
              end
            end
            CMD_ABS: begin
              if (!moving && freq_ok) begin
                target_position <= amount_r;
                if (abs_diff != '0) begin
                  move_direction <= abs_diff[POS_W];
                  state          <= abs_diff[POS_W] ? S_NEG : S_SPLIT;
                end
              end
            end
            CMD_BURST_END: begin
              if (burst != '0) begin
                moving <= 1'b1;
                if (full_left != '0) begin
                  full_left <= full_left - 1'b1;
                end else begin
                  remainder_pulses <= '0;
                  bursts_finished  <= 1'b1;
                end
                position <= move_direction ? (position - POS_W'(burst))
                                           : (position + POS_W'(burst));
              end else begin
                bursts_finished <= 1'b1;
                moving          <= 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
        S_NEG: begin
          state <= S_SPLIT;
        end
        S_SPLIT: begin
          full_left        <= move_dist[POS_W-1:CHUNK_LOG2];
          remainder_pulses <= move_dist[CHUNK_LOG2-1:0];
          bursts_finished  <= 1'b0;
          moving           <= 1'b1;
          state            <= S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Command capture, distance and result fields.
  always_ff @(posedge clk) begin
    if (cmd_xfer) begin
      cmd_r        <= cmd_ch.command;
      amount_r     <= cmd_ch.move_amount;
      freq_r       <= cmd_ch.frequency;
      dir_r        <= cmd_ch.direction;
      res_accepted <= 1'b0;
      res_burst    <= '0;
      res_reload   <= '0;
      res_done     <= 1'b0;
    end
    if (state == S_EXEC) begin
      move_dist <= (cmd_r == CMD_ABS) ? abs_diff[POS_W-1:0] : amount_r;
      if (cmd_r == CMD_BURST_END) begin
        res_burst <= burst;
        res_done  <= (burst == '0);
      end
    end
    if (state == S_NEG) begin
      move_dist <= ~move_dist + 1'b1;
    end
    if (state == S_SPLIT) begin
      res_accepted <= 1'b1;
    end
    if (state == S_DIV && div_rsp.done) begin
      res_reload <= RELOAD_W'(div_rsp.quotient - 1'b1);
    end
  end

  // Output register: loads when the sequencer finishes and the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_RESULT && out_free) begin
      out_valid <= 1'b1;
    end else if (res_xfer) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESULT && out_free) begin
      out_accepted <= res_accepted;
      out_burst    <= res_burst;
      out_dir      <= move_direction;
      out_reload   <= res_reload;
      out_position <= position;
      out_done     <= res_done;
      out_busy     <= moving;
    end
  end

  assign res_ch.valid          = out_valid;
  assign res_ch.accepted       = out_accepted;
  assign res_ch.burst_pulses   = out_burst;
  assign res_ch.step_direction = out_dir;
  assign res_ch.reload_period  = out_reload;
  assign res_ch.position       = out_position;
  assign res_ch.motion_done    = out_done;
  assign res_ch.busy_res       = out_busy;

`ifndef ASSERT_OFF
  // A stopped motor never has bursts pending.
  a_idle_no_bursts: assert property (@(posedge clk) disable iff (rst)
    !moving |-> bursts_finished)
    else $error("bursts pending while motion is stopped");

  // The divider only finishes while the sequencer waits on it.
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIV))
    else $error("divider finished outside the divide state");

  // An accepted move always carries a nonzero timer reload.
  a_accept_reload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_accepted) |-> (out_reload != '0))
    else $error("accepted move without a timer reload");

  // A command transfer is always followed by its evaluation.
  a_xfer_exec: assert property (@(posedge clk) disable iff (rst)
    cmd_xfer |=> (state == S_EXEC))
    else $error("command transfer not followed by evaluation");
`endif

endmodule
